// ===== sv/disjoint_set_union_find_macros.svh =====
// disjoint_set_union_find_macros.svh: assertion macros for the union-find engine
// expects clk and arst_n in the scope of each use, no other dependencies
`ifndef DISJOINT_SET_UNION_FIND_MACROS_SVH
`define DISJOINT_SET_UNION_FIND_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DSU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dsu_pkg.sv =====
// dsu_pkg: shared widths, request codes and controller/datapath command types
// no dependencies
package dsu_pkg;

	localparam int ID_W             = 8;
	localparam int SIZE_W           = 9;
	localparam int TYPE_W           = 2;
	localparam int DEF_NUM_ELEMENTS = 256;

	// request codes, code 3 means nothing
	typedef enum logic [TYPE_W-1:0] {
		REQ_ADD   = 2'd0,
		REQ_UNION = 2'd1,
		REQ_QUERY = 2'd2
	} req_t;

	// how the result registers are loaded
	typedef enum logic [2:0] {
		RES_NONE  = 3'd0,
		RES_ERR   = 3'd1,
		RES_NEW   = 3'd2,
		RES_SIZE  = 3'd3,
		RES_SAME  = 3'd4,
		RES_MERGE = 3'd5,
		RES_ZERO  = 3'd6
	} res_t;

	// size table read address select
	typedef enum logic {
		SEL_RA = 1'b0,
		SEL_RB = 1'b1
	} size_sel_t;

	typedef struct packed {
		logic      latch;     // capture the request
		logic      find_a;    // start a find at elem_a
		logic      find_b;    // start a find at elem_b
		logic      par_rd;    // read parent of the current node
		logic      walk_eval; // step up, or record root and rewind
		logic      comp_wr;   // point current node at root, step up
		logic      save_ra;
		logic      save_rb;
		logic      size_rd;
		size_sel_t size_sel;
		logic      keep_sa;   // hold the first size read
		logic      add_new;   // make elem_a a singleton
		logic      merge;     // link smaller root under larger
		res_t      res;
	} dsu_cmd_t;

	typedef struct packed {
		logic [TYPE_W-1:0] req_type;
		logic              a_in_range;
		logic              a_present;
		logic              b_present;
		logic              walk_done;
		logic              comp_done;
		logic              roots_eq;
	} dsu_stat_t;

endpackage

// ===== sv/dsu_datapath.sv =====
// dsu_datapath: request registers, parent and size memories, present marks, result registers
// depends on dsu_pkg; driven by dsu_ctrl through dsu_cmd_t
module dsu_datapath import dsu_pkg::*; #(
	parameter int NUM_ELEMENTS = DEF_NUM_ELEMENTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [ID_W-1:0]   elem_a,
	input  logic [ID_W-1:0]   elem_b,
	input  dsu_cmd_t          cmd,
	output dsu_stat_t         stat,
	output logic              done,
	output logic              same_set,
	output logic              status,
	output logic [SIZE_W-1:0] merged_size
);

	localparam int IDX_W  = $clog2(NUM_ELEMENTS);
	localparam int PRES_D = (NUM_ELEMENTS < (2 ** ID_W)) ? NUM_ELEMENTS : (2 ** ID_W);
	localparam int PRES_W = $clog2(PRES_D);

	logic [ID_W-1:0]   parent_mem [NUM_ELEMENTS];
	logic [SIZE_W-1:0] size_mem   [NUM_ELEMENTS];
	logic [PRES_D-1:0] pres_q;

	logic [TYPE_W-1:0] type_q;
	logic [ID_W-1:0]   a_q, b_q, cur_q, org_q, root_q, ra_q, rb_q;
	logic [ID_W-1:0]   par_rd_q;
	logic [SIZE_W-1:0] size_rd_q, sa_q;
	logic              done_q, same_q, status_q;
	logic [SIZE_W-1:0] msize_q;

	logic              a_in, b_in, a_pres, b_pres, walk_done;
	logic [SIZE_W-1:0] sum;
	logic              a_larger;
	logic              par_we, size_we;
	logic [IDX_W-1:0]  par_wa, size_wa;
	logic [ID_W-1:0]   par_wd;
	logic [SIZE_W-1:0] size_wd;

	assign a_in   = 32'(a_q) < 32'(NUM_ELEMENTS);
	assign b_in   = 32'(b_q) < 32'(NUM_ELEMENTS);
	assign a_pres = a_in && pres_q[PRES_W'(a_q)];
	assign b_pres = b_in && pres_q[PRES_W'(b_q)];

	// root reached when a node points at itself, or at nothing valid
	assign walk_done = (par_rd_q == cur_q) || (32'(par_rd_q) >= 32'(NUM_ELEMENTS));

	assign sum      = sa_q + size_rd_q;
	assign a_larger = sa_q > size_rd_q;

	assign stat.req_type   = type_q;
	assign stat.a_in_range = a_in;
	assign stat.a_present  = a_pres;
	assign stat.b_present  = b_pres;
	assign stat.walk_done  = walk_done;
	assign stat.comp_done  = cur_q == root_q;
	assign stat.roots_eq   = ra_q == rb_q;

	// memory write port muxing
	always_comb begin
		par_we  = 1'b0;
		par_wa  = IDX_W'(cur_q);
		par_wd  = root_q;
		size_we = 1'b0;
		size_wa = IDX_W'(a_q);
		size_wd = SIZE_W'(1);
		if (cmd.comp_wr) begin
			par_we = 1'b1;
		end else if (cmd.add_new) begin
			par_we  = 1'b1;
			par_wa  = IDX_W'(a_q);
			par_wd  = a_q;
			size_we = 1'b1;
		end else if (cmd.merge) begin
			par_we  = 1'b1;
			size_we = 1'b1;
			size_wd = sum;
			if (a_larger) begin
				par_wa  = IDX_W'(rb_q);
				par_wd  = ra_q;
				size_wa = IDX_W'(ra_q);
			end else begin
				par_wa  = IDX_W'(ra_q);
				par_wd  = rb_q;
				size_wa = IDX_W'(rb_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			parent_mem[par_wa] <= par_wd;
		end
		if (cmd.par_rd) begin
			par_rd_q <= parent_mem[IDX_W'(cur_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (size_we) begin
			size_mem[size_wa] <= size_wd;
		end
		if (cmd.size_rd) begin
			size_rd_q <= size_mem[IDX_W'((cmd.size_sel == SEL_RB) ? rb_q : ra_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_q <= '0;
		end else if (cmd.add_new) begin
			pres_q[PRES_W'(a_q)] <= 1'b1;
		end
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			type_q <= req_type;
			a_q    <= elem_a;
			b_q    <= elem_b;
		end
		if (cmd.find_a) begin
			cur_q <= a_q;
			org_q <= a_q;
		end else if (cmd.find_b) begin
			cur_q <= b_q;
			org_q <= b_q;
		end else if (cmd.walk_eval) begin
			if (walk_done) begin
				root_q <= cur_q;
				cur_q  <= org_q;
			end else begin
				cur_q <= par_rd_q;
			end
		end else if (cmd.comp_wr) begin
			cur_q <= par_rd_q;
		end
		if (cmd.save_ra) begin
			ra_q <= root_q;
		end
		if (cmd.save_rb) begin
			rb_q <= root_q;
		end
		if (cmd.keep_sa) begin
			sa_q <= size_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res != RES_NONE;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.res)
			RES_ERR: begin
				same_q   <= 1'b0;
				status_q <= 1'b1;
				msize_q  <= '0;
			end
			RES_NEW: begin
				same_q   <= 1'b0;
				status_q <= 1'b0;
				msize_q  <= SIZE_W'(1);
			end
			RES_SIZE: begin
				same_q   <= 1'b0;
				status_q <= 1'b0;
				msize_q  <= size_rd_q;
			end
			RES_SAME: begin
				same_q   <= ra_q == rb_q;
				status_q <= 1'b0;
				msize_q  <= '0;
			end
			RES_MERGE: begin
				same_q   <= 1'b0;
				status_q <= 1'b0;
				msize_q  <= sum;
			end
			RES_ZERO: begin
				same_q   <= 1'b0;
				status_q <= 1'b0;
				msize_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	assign done        = done_q;
	assign same_set    = same_q;
	assign status      = status_q;
	assign merged_size = msize_q;

endmodule

// ===== sv/dsu_ctrl.sv =====
// dsu_ctrl: request sequencer for the union-find engine
// depends on dsu_pkg; drives dsu_datapath through dsu_cmd_t
module dsu_ctrl import dsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dsu_stat_t stat,
	output dsu_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_DECIDE   = 10'b00_0000_0010,
		ST_WALK_RD  = 10'b00_0000_0100,
		ST_WALK_EV  = 10'b00_0000_1000,
		ST_COMP_CHK = 10'b00_0001_0000,
		ST_COMP_WR  = 10'b00_0010_0000,
		ST_ROOTS    = 10'b00_0100_0000,
		ST_SIZE_RD  = 10'b00_1000_0000,
		ST_SIZE_A   = 10'b01_0000_0000,
		ST_SIZE_B   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   find_b_q, find_b_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			find_b_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			find_b_q <= find_b_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		find_b_d = find_b_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				find_b_d = 1'b0;
				case (stat.req_type)
					REQ_ADD: begin
						if (!stat.a_in_range) begin
							cmd.res = RES_ERR;
							state_d = ST_IDLE;
						end else if (!stat.a_present) begin
							cmd.add_new = 1'b1;
							cmd.res     = RES_NEW;
							state_d     = ST_IDLE;
						end else begin
							cmd.find_a = 1'b1;
							state_d    = ST_WALK_RD;
						end
					end
					REQ_UNION, REQ_QUERY: begin
						if (!stat.a_present || !stat.b_present) begin
							cmd.res = RES_ERR;
							state_d = ST_IDLE;
						end else begin
							cmd.find_a = 1'b1;
							state_d    = ST_WALK_RD;
						end
					end
					default: begin
						cmd.res = RES_ZERO;
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_WALK_RD: begin
				cmd.par_rd = 1'b1;
				state_d    = ST_WALK_EV;
			end
			ST_WALK_EV: begin
				cmd.walk_eval = 1'b1;
				state_d       = stat.walk_done ? ST_COMP_CHK : ST_WALK_RD;
			end
			ST_COMP_CHK: begin
				if (!stat.comp_done) begin
					cmd.par_rd = 1'b1;
					state_d    = ST_COMP_WR;
				end else if (find_b_q) begin
					cmd.save_rb = 1'b1;
					state_d     = ST_ROOTS;
				end else begin
					cmd.save_ra = 1'b1;
					if (stat.req_type == REQ_ADD) begin
						state_d = ST_SIZE_RD;
					end else begin
						cmd.find_b = 1'b1;
						find_b_d   = 1'b1;
						state_d    = ST_WALK_RD;
					end
				end
			end
			ST_COMP_WR: begin
				cmd.comp_wr = 1'b1;
				state_d     = ST_COMP_CHK;
			end
			ST_ROOTS: begin
				if (stat.req_type == REQ_QUERY) begin
					cmd.res = RES_SAME;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SIZE_RD;
				end
			end
			ST_SIZE_RD: begin
				cmd.size_rd  = 1'b1;
				cmd.size_sel = SEL_RA;
				state_d      = ST_SIZE_A;
			end
			ST_SIZE_A: begin
				if (stat.req_type == REQ_ADD || stat.roots_eq) begin
					cmd.res = RES_SIZE;
					state_d = ST_IDLE;
				end else begin
					cmd.keep_sa  = 1'b1;
					cmd.size_rd  = 1'b1;
					cmd.size_sel = SEL_RB;
					state_d      = ST_SIZE_B;
				end
			end
			ST_SIZE_B: begin
				cmd.merge = 1'b1;
				cmd.res   = RES_MERGE;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule

// ===== sv/disjoint_set_union_find.sv =====
// disjoint_set_union_find: top level of the union-find engine with path compression
// depends on dsu_pkg, dsu_ctrl, dsu_datapath and disjoint_set_union_find_macros.svh
//
//  channel   handshake              beat
//  request   start & !busy          req_type, elem_a, elem_b
//  result    done (one-cycle pulse) same_set, status, merged_size
//
// one request in flight at a time; busy stays high from the accepting edge
// until the result beat is on the ports, so a new start can be taken in the
// done cycle. errors, new adds and unknown types are answered from the decide
// state; a find walks a path to its root with a parent read and a step per
// link, then rewinds and compresses it with a read and a write per link. add
// of a present element then reads the root size, query compares the roots,
// and union reads both sizes and merges, or reports the size within one set.
// arst_n clears the controller, the present marks and the result strobe;
// the parent and size memories are not cleared. the receiver cannot stall.
`include "disjoint_set_union_find_macros.svh"

module disjoint_set_union_find import dsu_pkg::*; #(
	parameter int NUM_ELEMENTS = DEF_NUM_ELEMENTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [TYPE_W-1:0] req_type,
	input  logic [ID_W-1:0]   elem_a,
	input  logic [ID_W-1:0]   elem_b,
	output logic              done,
	output logic              same_set,
	output logic              status,
	output logic [SIZE_W-1:0] merged_size
);

	// command and status between sequencer and datapath
	dsu_cmd_t  cmd;
	dsu_stat_t stat;

	// sequencer: decides request kind, runs finds, size reads and merge
	dsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: tables, walk pointers and result registers
	dsu_datapath #(
		.NUM_ELEMENTS (NUM_ELEMENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.elem_a      (elem_a),
		.elem_b      (elem_b),
		.cmd         (cmd),
		.stat        (stat),
		.done        (done),
		.same_set    (same_set),
		.status      (status),
		.merged_size (merged_size)
	);

	// result beat only appears once the sequencer is back to idle
	`DSU_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")
	// an accepted request keeps the engine busy in the next cycle
	`DSU_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted beat not taken")
	// error beats carry no size and no match
	`DSU_ASSERT_NOW(a_err_clean, done && status, !same_set && merged_size == '0, "dirty error beat")
	// a match only comes from a successful query
	`DSU_ASSERT_NOW(a_same_clean, done && same_set, !status && merged_size == '0, "dirty match beat")

endmodule
